@@ rtl/core/fwpt_pkg.sv @@
// fwpt_pkg: shared types and constants for the fused window patch table.
// No dependencies.
`timescale 1ns / 1ps
package fwpt_pkg;
    localparam int TableEntries  = 16;
    localparam int MaxWindow     = 8;
    localparam int CooldownTicks = 4096;
    localparam int SlotW         = 4;
    localparam int CoolW         = 12;  // log2 of the cooldown

    localparam logic [1:0] REQ_INSTALL = 2'd0;
    localparam logic [1:0] REQ_TRY     = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_INVAL   = 2'd3;

    localparam logic [2:0] ST_REJECT  = 3'd0;
    localparam logic [2:0] ST_INSTALL = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_HIT     = 3'd3;
    localparam logic [2:0] ST_FAIL    = 3'd4;
    localparam logic [2:0] ST_TICK    = 3'd5;
    localparam logic [2:0] ST_SWEPT   = 3'd6;
    localparam logic [2:0] ST_INVAL   = 3'd7;

    // entry record shifted around the ring
    typedef struct packed {
        logic [31:0] addr;
        logic        active;
        logic [3:0]  len;
        logic [63:0] ops;
        logic [63:0] hits;
        logic [63:0] last_use;
    } entry_t;

    // what the controller asks of the cell currently at the head
    typedef struct packed {
        logic        shift;    // rotate ring one place
        logic        clear;    // wipe all cells
        logic        wr;       // overwrite head with wr_entry
        logic        deact;    // clear head active bit
        logic        bump;     // count hit and restamp head
        logic        sweep;    // deactivate head if idle
        logic [63:0] tick;
    } cell_ctl_t;
endpackage

@@ rtl/core/fwpt_cell.sv @@
// fwpt_cell: one table entry of the ring; takes its neighbour's entry on a shift.
// Depends on fwpt_pkg.
`timescale 1ns / 1ps
module fwpt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  fwpt_pkg::cell_ctl_t ctl,
    input  logic               is_head,
    input  fwpt_pkg::entry_t   wr_entry,
    input  fwpt_pkg::entry_t   prev_entry,
    output fwpt_pkg::entry_t   entry,
    output fwpt_pkg::entry_t   pass_entry
);
    import fwpt_pkg::*;
    entry_t entry_reg, entry_next;
    logic [63:0] age;

    // sweep runs while the ring turns, so it is applied to the entry on its way out
    always_comb begin
        pass_entry = entry_reg;
        age = ctl.tick - entry_reg.last_use;
        if (is_head && ctl.sweep && entry_reg.addr != '0 && age > 64'(CooldownTicks))
            pass_entry.active = 1'b0;
    end

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift) begin
            entry_next = prev_entry;
        end else if (is_head) begin
            if (ctl.wr) begin
                entry_next = wr_entry;
            end else if (ctl.deact) begin
                entry_next.active = 1'b0;
            end else if (ctl.bump) begin
                if (entry_reg.hits != '1) entry_next.hits = entry_reg.hits + 64'd1;
                entry_next.last_use = ctl.tick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
endmodule

@@ rtl/core/fused_window_patch_table.sv @@
// fused_window_patch_table: top level, ring of entry cells plus sequencing control.
// Depends on fwpt_pkg and fwpt_cell.
//
//  channel | ports                                   | direction
//  s_      | req_type start_addr opcode window_*     | in, valid/ready
//          | handler_ok tick_index                   |
//  m_      | status slot hit_total out_length        | out, valid/ready
//          | out_opcodes table_generation            |
//
// Entries sit in a ring of 16 cells that rotates one place a cycle while a
// request scans or seeks its slot; slot k is at the head when the rotation
// count equals k. Install and try take one full turn to search, then, unless
// a try misses, rotate to bring the chosen slot to the head and act on it.
// A swept tick takes the full turn; rejects, zero-address tries, plain ticks
// and invalidate answer the cycle after acceptance. One request at a time;
// input is taken again the cycle after the result is accepted. Reset empties
// the table at once; a stalled result holds and blocks new input.
`timescale 1ns / 1ps
module fused_window_patch_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_start_addr,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_window_length,
    input  logic [63:0] s_window_opcodes,
    input  logic        s_handler_ok,
    input  logic [63:0] s_tick_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot,
    output logic [63:0] m_hit_total,
    output logic [3:0]  m_out_length,
    output logic [63:0] m_out_opcodes,
    output logic [31:0] m_table_generation
);
    import fwpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;  // one turn: search, victim, sweep
    localparam logic [1:0] S_ACT  = 2'd2;  // rotate to chosen slot and act
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [SlotW-1:0] rot_reg, rot_next;   // slot index at the head
    logic [SlotW:0]   cnt_reg, cnt_next;
    logic [4:0]  fill_reg, fill_next;
    logic [63:0] tick_reg, tick_next;
    logic [31:0] gen_reg, gen_next;

    logic [1:0]  req_reg;
    logic [31:0] addr_reg;
    logic [7:0]  opc_reg;
    logic [3:0]  len_reg;
    logic [63:0] ops_reg;
    logic        ok_reg;

    logic        found_reg, found_next;
    logic [SlotW-1:0] fslot_reg, fslot_next;
    logic        empty_reg, empty_next;
    logic [SlotW-1:0] vslot_reg, vslot_next;
    logic [63:0] oldest_reg, oldest_next;
    logic [SlotW-1:0] tgt_reg, tgt_next;

    logic [2:0]  m_status_reg, m_status_next;
    logic [3:0]  m_slot_reg, m_slot_next;
    logic [63:0] m_hits_reg, m_hits_next;
    logic [3:0]  m_len_reg, m_len_next;
    logic [63:0] m_ops_reg, m_ops_next;
    logic [31:0] m_gen_reg, m_gen_next;

    cell_ctl_t ctl;
    entry_t    wr_entry;
    entry_t    cells [TableEntries];
    entry_t    passed [TableEntries];
    entry_t    head;
    logic      accept, bad_inst, is_sweep;
    logic [63:0] mask;

    assign head = cells[0];
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    genvar g;
    generate
        for (g = 0; g < TableEntries; g++) begin : g_cell
            fwpt_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .is_head(g == 0), .wr_entry(wr_entry),
                .prev_entry(passed[(g + 1) % TableEntries]), .entry(cells[g]),
                .pass_entry(passed[g])
            );
        end
    endgenerate

    always_comb begin
        mask = '1;
        if (len_reg < 4'd8) mask = (64'd1 << {len_reg[2:0], 3'b000}) - 64'd1;
        wr_entry = '{addr: addr_reg, active: 1'b1, len: len_reg,
                     ops: ops_reg & mask, hits: 64'd0, last_use: tick_reg};
    end

    always_comb begin
        state_next = state_reg; rot_next = rot_reg; cnt_next = cnt_reg;
        fill_next = fill_reg; tick_next = tick_reg; gen_next = gen_reg;
        found_next = found_reg; fslot_next = fslot_reg; empty_next = empty_reg;
        vslot_next = vslot_reg; oldest_next = oldest_reg; tgt_next = tgt_reg;
        m_status_next = m_status_reg; m_slot_next = m_slot_reg;
        m_hits_next = m_hits_reg; m_len_next = m_len_reg;
        m_ops_next = m_ops_reg; m_gen_next = m_gen_reg;
        ctl = '0;
        ctl.tick = tick_reg;
        bad_inst = (s_start_addr == '0) || (s_window_length == '0) ||
                   (s_window_length > 8'(MaxWindow));
        is_sweep = (s_tick_index != '0) && (s_tick_index[CoolW-1:0] == '0);
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_gen_next = gen_reg;
                    m_slot_next = '0; m_hits_next = '0;
                    m_len_next = '0; m_ops_next = '0;
                    cnt_next = '0; found_next = 1'b0; empty_next = 1'b0;
                    oldest_next = '1; vslot_next = '0;
                    state_next = S_SCAN;
                    case (s_req_type)
                        REQ_INSTALL: begin
                            if (bad_inst) begin
                                m_status_next = ST_REJECT; state_next = S_OUT;
                            end
                        end
                        REQ_TRY: begin
                            if (s_start_addr == '0) begin
                                m_status_next = ST_MISS; state_next = S_OUT;
                            end
                        end
                        REQ_TICK: begin
                            tick_next = s_tick_index;
                            if (!is_sweep) begin
                                m_status_next = ST_TICK; state_next = S_OUT;
                            end
                        end
                        default: begin
                            ctl.clear = 1'b1;
                            rot_next = '0; fill_next = '0;
                            gen_next = gen_reg + 32'd1;
                            m_gen_next = gen_reg + 32'd1;
                            m_status_next = ST_INVAL; state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // head holds slot rot_reg; slots at or beyond fill are empty
                if (req_reg == REQ_TICK) begin
                    ctl.sweep = head.active && ({1'b0, rot_reg} < fill_reg);
                end
                if (!found_reg && head.addr == addr_reg && {1'b0, rot_reg} < fill_reg) begin
                    found_next = 1'b1; fslot_next = rot_reg;
                end
                // a turn may start at any rotation, so ties go to the lower slot
                if (!empty_reg) begin
                    if (head.addr == '0) begin
                        empty_next = 1'b1; vslot_next = rot_reg;
                    end else if (head.last_use < oldest_reg ||
                                 (head.last_use == oldest_reg && rot_reg < vslot_reg)) begin
                        oldest_next = head.last_use; vslot_next = rot_reg;
                    end
                end
                ctl.shift = 1'b1;
                rot_next = rot_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(TableEntries - 1)) begin
                    state_next = S_ACT;
                    if (req_reg == REQ_TICK) begin
                        m_status_next = ST_SWEPT; state_next = S_OUT;
                    end else if (req_reg == REQ_TRY) begin
                        if (!found_next) begin
                            m_status_next = ST_MISS; state_next = S_OUT;
                        end
                        tgt_next = fslot_next;
                    end else begin
                        if (found_next) tgt_next = fslot_next;
                        else if (fill_reg < 5'(TableEntries)) begin
                            tgt_next = fill_reg[SlotW-1:0];
                            fill_next = fill_reg + 5'd1;
                        end else tgt_next = vslot_next;
                    end
                end
            end
            S_ACT: begin
                if (rot_reg != tgt_reg) begin
                    ctl.shift = 1'b1;
                    rot_next = rot_reg + 1'b1;
                end else begin
                    m_slot_next = rot_reg;
                    m_len_next = head.len;
                    m_ops_next = head.ops;
                    m_hits_next = head.hits;
                    if (req_reg == REQ_INSTALL) begin
                        ctl.wr = 1'b1;
                        m_status_next = ST_INSTALL;
                        m_len_next = wr_entry.len; m_ops_next = wr_entry.ops;
                        m_hits_next = '0;
                    end else if (!head.active || head.len == '0 ||
                                 head.ops[7:0] != opc_reg) begin
                        m_status_next = ST_MISS;
                        m_slot_next = '0; m_len_next = '0;
                        m_ops_next = '0; m_hits_next = '0;
                    end else if (!ok_reg) begin
                        ctl.deact = 1'b1;
                        m_status_next = ST_FAIL;
                    end else begin
                        ctl.bump = 1'b1;
                        m_status_next = ST_HIT;
                        if (head.hits != '1) m_hits_next = head.hits + 64'd1;
                    end
                    state_next = S_OUT;
                end
            end
            default: begin
                if (m_ready) state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rot_reg   <= '0;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            tick_reg  <= '0;
            gen_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            tick_reg  <= tick_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req_type;
            addr_reg <= s_start_addr;
            opc_reg  <= s_opcode;
            len_reg  <= s_window_length[3:0];
            ops_reg  <= s_window_opcodes;
            ok_reg   <= s_handler_ok;
        end
        found_reg <= found_next; fslot_reg <= fslot_next;
        empty_reg <= empty_next; vslot_reg <= vslot_next;
        oldest_reg <= oldest_next; tgt_reg <= tgt_next;
        m_status_reg <= m_status_next; m_slot_reg <= m_slot_next;
        m_hits_reg <= m_hits_next; m_len_reg <= m_len_next;
        m_ops_reg <= m_ops_next; m_gen_reg <= m_gen_next;
    end

    assign m_status = m_status_reg;
    assign m_slot = m_slot_reg;
    assign m_hit_total = m_hits_reg;
    assign m_out_length = m_len_reg;
    assign m_out_opcodes = m_ops_reg;
    assign m_table_generation = m_gen_reg;
endmodule

@@ dv/fused_window_patch_table_tb.sv @@
// fused_window_patch_table_tb: self-checking bench for the fused window patch table.
// Depends on fwpt_pkg and the fused_window_patch_table RTL; directed table then random requests.
`timescale 1ns / 1ps
module fused_window_patch_table_tb;
    import fwpt_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int RandReqs   = 1430;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_INVAL;
    logic [31:0] s_start_addr = '0;
    logic [7:0]  s_opcode = '0;
    logic [7:0]  s_window_length = '0;
    logic [63:0] s_window_opcodes = '0;
    logic        s_handler_ok = 1'b0;
    logic [63:0] s_tick_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_slot;
    logic [63:0] m_hit_total;
    logic [3:0]  m_out_length;
    logic [63:0] m_out_opcodes;
    logic [31:0] m_table_generation;

    fused_window_patch_table u_top (.*);

    always #4 aclk = ~aclk;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] addr;
        logic [7:0]  opc;
        logic [7:0]  len;
        logic [63:0] ops;
        logic        ok;
        logic [63:0] tick;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [63:0] hits;
        logic [3:0]  len;
        logic [63:0] ops;
        logic [31:0] gen;
    } outcome_t;

    typedef struct {
        request_t rq;
        logic     fixed;   // use typed-in outcome
        outcome_t res;
    } row_t;

    // predictor state
    logic [31:0] tbl_addr [TableEntries];
    logic        tbl_act  [TableEntries];
    logic [3:0]  tbl_len  [TableEntries];
    logic [63:0] tbl_ops  [TableEntries];
    logic [63:0] tbl_hits [TableEntries];
    logic [63:0] tbl_last [TableEntries];
    int          tbl_fill;
    logic [63:0] now_tick;
    logic [31:0] gen_count;

    outcome_t pending_results[$];
    request_t to_send[$];
    int       n_errors = 0;
    int       n_accepted = 0;
    int       n_results = 0;
    int       n_hits = 0;
    int       n_sweeps = 0;
    int       n_evictions = 0;
    logic     long_stall = 1'b0;

    function automatic void clear_table();
        for (int i = 0; i < TableEntries; i++) begin
            tbl_addr[i] = '0; tbl_act[i] = 1'b0; tbl_len[i] = '0;
            tbl_ops[i] = '0; tbl_hits[i] = '0; tbl_last[i] = '0;
        end
        tbl_fill = 0;
    endfunction

    function automatic int find_entry(logic [31:0] a);
        if (a == 0) return -1;
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic outcome_t entry_outcome(logic [2:0] st, int s);
        outcome_t o;
        o.status = st; o.slot = s[3:0]; o.hits = tbl_hits[s];
        o.len = tbl_len[s]; o.ops = tbl_ops[s]; o.gen = gen_count;
        return o;
    endfunction

    function automatic outcome_t predict_table(request_t r);
        outcome_t o;
        int s;
        logic [63:0] oldest;
        o = '{ST_REJECT, '0, '0, '0, '0, gen_count};
        case (r.req)
            REQ_INSTALL: begin
                if (r.addr == 0 || r.len == 0 || r.len > MaxWindow) return o;
                s = find_entry(r.addr);
                if (s < 0 && tbl_fill < TableEntries) begin
                    s = tbl_fill; tbl_fill++;
                end else if (s < 0) begin
                    n_evictions++;
                    oldest = '1; s = 0;
                    for (int i = TableEntries - 1; i >= 0; i--)
                        if (tbl_last[i] <= oldest) begin
                            oldest = tbl_last[i]; s = i;
                        end
                    // strict first-min: redo forward to respect tie order
                    oldest = '1; s = 0;
                    for (int i = 0; i < TableEntries; i++)
                        if (tbl_last[i] < oldest) begin
                            oldest = tbl_last[i]; s = i;
                        end
                end
                tbl_addr[s] = r.addr; tbl_len[s] = r.len[3:0];
                tbl_ops[s] = (r.len >= 8) ? r.ops : r.ops & ((64'd1 << (8 * r.len)) - 1);
                tbl_act[s] = 1'b1; tbl_hits[s] = '0; tbl_last[s] = now_tick;
                return entry_outcome(ST_INSTALL, s);
            end
            REQ_TRY: begin
                o.status = ST_MISS;
                s = find_entry(r.addr);
                if (s < 0) return o;
                if (!tbl_act[s] || tbl_len[s] == 0 || tbl_ops[s][7:0] != r.opc) return o;
                if (!r.ok) begin
                    tbl_act[s] = 1'b0;
                    return entry_outcome(ST_FAIL, s);
                end
                n_hits++;
                if (tbl_hits[s] != '1) tbl_hits[s]++;
                tbl_last[s] = now_tick;
                return entry_outcome(ST_HIT, s);
            end
            REQ_TICK: begin
                now_tick = r.tick;
                o.status = ST_TICK;
                if (r.tick == 0 || r.tick[CoolW-1:0] != 0) return o;
                n_sweeps++;
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_act[i] && tbl_addr[i] != 0
                        && (r.tick - tbl_last[i]) > 64'(CooldownTicks))
                        tbl_act[i] = 1'b0;
                o.status = ST_SWEPT;
                return o;
            end
            default: begin
                clear_table();
                gen_count++;
                o.status = ST_INVAL; o.gen = gen_count;
                return o;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
        n_errors++;
    endtask

    function automatic request_t mk(logic [1:0] q, logic [31:0] a, logic [7:0] c,
                                    logic [7:0] l, logic [63:0] p, logic k,
                                    logic [63:0] t);
        request_t r;
        r = '{q, a, c, l, p, k, t};
        return r;
    endfunction

    // sender: bursts and gaps; the request leaves the queue once accepted
    initial begin : sender
        int burst;
        wait (aresetn);
        forever begin
            burst = $urandom_range(1, 12);
            while (burst > 0) begin
                if (to_send.size() == 0) begin
                    @(posedge aclk);
                    s_valid <= 1'b0;
                end else begin
                    s_req_type <= to_send[0].req; s_start_addr <= to_send[0].addr;
                    s_opcode <= to_send[0].opc; s_window_length <= to_send[0].len;
                    s_window_opcodes <= to_send[0].ops; s_handler_ok <= to_send[0].ok;
                    s_tick_index <= to_send[0].tick;
                    s_valid <= 1'b1;
                    @(posedge aclk);
                    while (!s_ready) @(posedge aclk);
                    void'(to_send.pop_front());
                    n_accepted++;
                    burst--;
                    if (burst == 0 || to_send.size() == 0) s_valid <= 1'b0;
                end
            end
            repeat ($urandom_range(0, 1) ? 1 : $urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin : receiver
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (long_stall) m_ready <= 1'b0;
            else if ((phase / 64) % 3 == 2) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // checker: predict at acceptance order matches result order (one in flight)
    always @(posedge aclk) begin
        outcome_t w;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("unexpected result status %0d", m_status);
                n_errors++;
            end else begin
                w = pending_results.pop_front();
                if (m_status !== w.status) report_mismatch("status", m_status, w.status);
                if (m_slot !== w.slot) report_mismatch("slot", m_slot, w.slot);
                if (m_hit_total !== w.hits) report_mismatch("hit_total", m_hit_total, w.hits);
                if (m_out_length !== w.len) report_mismatch("out_length", m_out_length, w.len);
                if (m_out_opcodes !== w.ops) report_mismatch("out_opcodes", m_out_opcodes, w.ops);
                if (m_table_generation !== w.gen)
                    report_mismatch("table_generation", m_table_generation, w.gen);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("fused_window_patch_table_tb: FAIL");
            $finish;
        end
    end

    // queue a request; expectation computed now, in send order
    task automatic push_request(request_t r, logic fixed, outcome_t want);
        outcome_t p;
        p = predict_table(r);
        if (fixed && p != want) begin
            $display("directed row disagrees with predictor, status %0d", want.status);
            n_errors++;
        end
        pending_results.push_back(p);
        to_send.push_back(r);
    endtask

    function automatic logic [31:0] pick_addr();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3) return 32'hFFFF_FFFF;
        if (k < 5) return '0;
        if (k < 10) return $urandom();
        return 32'h1000 + 32'($urandom_range(0, 23)) * 4;
    endfunction

    initial begin : stimulus
        row_t rows[$];
        request_t r;
        outcome_t none;
        logic [31:0] a;
        int k, s;
        none = '{ST_REJECT, '0, '0, '0, '0, '0};
        clear_table();
        now_tick = '0; gen_count = '0;

        rows.push_back('{mk(REQ_TRY, 32'h10, 8'h01, 0, 0, 1, 0), 1,
                         '{ST_MISS, 0, 0, 0, 0, 0}});
        rows.push_back('{mk(REQ_INSTALL, 0, 0, 3, '1, 0, 0), 1, none});
        rows.push_back('{mk(REQ_INSTALL, 32'h10, 0, 0, '1, 0, 0), 1, none});
        rows.push_back('{mk(REQ_INSTALL, 32'h10, 0, 9, '1, 0, 0), 1, none});
        rows.push_back('{mk(REQ_INSTALL, 32'h10, 0, 8'hFF, '1, 0, 0), 1, none});
        rows.push_back('{mk(REQ_INSTALL, 32'hFFFF_FFFF, 0, 8, '1, 1, '1), 1,
                         '{ST_INSTALL, 0, 0, 4'd8, '1, 0}});
        rows.push_back('{mk(REQ_INSTALL, 32'h10, 0, 1, 64'hA5A5_0000_1234_56C3, 0, 0), 1,
                         '{ST_INSTALL, 1, 0, 4'd1, 64'hC3, 0}});
        rows.push_back('{mk(REQ_INSTALL, 32'h20, 0, 3, 64'h0123_4567_89AB_CDEF, 0, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h10, 8'hC3, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h10, 8'hC3, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h10, 8'hC4, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 0, 8'h00, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h20, 8'hEF, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h20, 8'hEF, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, 64'd0), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, 64'd4095), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, 64'd4096), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, 64'd8192), 0, none});
        rows.push_back('{mk(REQ_TRY, 32'h10, 8'hC3, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_F000), 0, none});
        rows.push_back('{mk(REQ_TICK, 0, 0, 0, 0, 0, '1), 0, none});
        rows.push_back('{mk(REQ_INVAL, '1, '1, '1, '1, 1, '1), 1,
                         '{ST_INVAL, 0, 0, 0, 0, 32'd1}});
        rows.push_back('{mk(REQ_TRY, 32'hFFFF_FFFF, 8'hFF, 0, 0, 1, 0), 1,
                         '{ST_MISS, 0, 0, 0, 0, 32'd1}});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) push_request(rows[i].rq, rows[i].fixed, rows[i].res);

        for (int n = 0; n < RandReqs; n++) begin
            // long receiver hold-off while requests keep coming
            if (n == 300) begin
                wait (to_send.size() == 0);
                long_stall = 1'b1;
                fork
                    begin repeat (400) @(posedge aclk); long_stall = 1'b0; end
                join_none
            end
            k = $urandom_range(0, 99);
            r = mk(REQ_TRY, pick_addr(), 8'($urandom()), 8'($urandom()),
                   {$urandom(), $urandom()}, 1'($urandom_range(0, 1)),
                   {$urandom(), $urandom()});
            if (k < 35) begin
                r.req = REQ_INSTALL;
                if ($urandom_range(0, 9) != 0) r.len = 8'($urandom_range(1, MaxWindow));
            end else if (k < 80) begin
                r.req = REQ_TRY;
                r.ok = ($urandom_range(0, 9) != 0);
                s = find_entry(r.addr);
                if (s >= 0 && $urandom_range(0, 3) != 0) r.opc = tbl_ops[s][7:0];
            end else if (k < 98) begin
                r.req = REQ_TICK;
                case ($urandom_range(0, 3))
                    0: r.tick = now_tick + 64'($urandom_range(1, 3000));
                    1: r.tick = {now_tick[63:CoolW] + 52'($urandom_range(1, 2)),
                                 {CoolW{1'b0}}};
                    2: r.tick = {now_tick[63:CoolW], {CoolW{1'b0}}};
                    default: ;
                endcase
            end else begin
                r.req = REQ_INVAL;
            end
            push_request(r, 1'b0, none);
            while (to_send.size() > 4) @(posedge aclk);
        end

        wait (to_send.size() == 0);
        fork
            wait (pending_results.size() == 0);
            begin repeat (WatchLimit) @(posedge aclk); end
        join_any
        repeat (40) @(posedge aclk);
        $display("covered %0d requests, %0d results: %0d hits, %0d sweeps, %0d evictions",
                 n_accepted, n_results, n_hits, n_sweeps, n_evictions);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("fused_window_patch_table_tb: PASS");
        end else begin
            $display("fused_window_patch_table_tb: FAIL");
        end
        $finish;
    end
endmodule
